// ----- rtl/core/assert_macros.svh -----
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion shorthands: overlapping and next-cycle implication.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// ante |-> cons, checked on every rising clock edge outside reset
`define ASSERT_IMPL(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// ante |=> cons
`define ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/core/mlcic_pkg.sv -----
// ----------------------------------------------------------------------------
// mlcic_pkg
// Shared types and constants of the multilevel change-id cache.
// ----------------------------------------------------------------------------
package mlcic_pkg;

  localparam int DEF_NUM_LEVELS = 5;
  localparam int DEF_MAX_BLOCKS = 256;

  localparam int ID_W      = 32;
  localparam int BLK_W     = 8;
  localparam int CMD_W     = 2;
  localparam int CFG_W     = 9;
  localparam int CFG_IDX_W = 2;
  localparam int LVL_OUT_W = 3;

  localparam logic [CMD_W-1:0] CMD_SET  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_FILL = 2'd1;

  localparam logic [CFG_IDX_W-1:0] REG_BLOCKS_IN_USE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_NOTIFY_ENABLE = 2'd1;

  localparam logic [CFG_W-1:0] BLOCKS_IN_USE_RST = 9'd256;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_LOOK,
    ST_MATCH,
    ST_OLDEST,
    ST_DECIDE,
    ST_SWEEP,
    ST_NEWEST,
    ST_WRITE,
    ST_SCAN,
    ST_SCAN_END,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic eq;
    logic lt;
  } cmp_res_t;

endpackage

// ----- rtl/core/multilevel_change_id_cache_top.sv -----
// ----------------------------------------------------------------------------
// multilevel_change_id_cache_top
// Multilevel change-id cache: per-level change ids and block membership
// bitmaps, driven by a sequencer around one shared comparator.
// ----------------------------------------------------------------------------
//  channel   | handshake           | payload
//  ----------+---------------------+----------------------------------------
//  command   | start / busy        | cmd, block_index, change_id
//  result    | done (1-cycle)      | hit, id_out, level_used, writeback_req,
//            |                     | level_complete, latest_id, bad_block
//  config    | cfg_valid/cfg_ready | cfg_index, cfg_data
//
//  Steps: a bad block goes straight to the result; a lookup reads the row
//  and, on a hit, the lowest level's id. Set/fill compares every level; if
//  none matches it finds the oldest, and a replaced level is swept from every
//  row on the memory write port. The row is then written, and a completion
//  scan follows when notify is on and the block ends up cached (one memory
//  read per block). After reset the bitmap memory is cleared, busy high.
//  Results cannot be stalled; done pulses for one cycle per item.
// ----------------------------------------------------------------------------
module multilevel_change_id_cache_top #(
  parameter int NUM_LEVELS = mlcic_pkg::DEF_NUM_LEVELS,
  parameter int MAX_BLOCKS = mlcic_pkg::DEF_MAX_BLOCKS
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             start,
  output logic                             busy,
  input  logic [mlcic_pkg::CMD_W-1:0]      cmd,
  input  logic [mlcic_pkg::BLK_W-1:0]      block_index,
  input  logic [mlcic_pkg::ID_W-1:0]       change_id,
  output logic                             done,
  output logic                             hit,
  output logic [mlcic_pkg::ID_W-1:0]       id_out,
  output logic [mlcic_pkg::LVL_OUT_W-1:0]  level_used,
  output logic                             writeback_req,
  output logic                             level_complete,
  output logic [mlcic_pkg::ID_W-1:0]       latest_id,
  output logic                             bad_block,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [mlcic_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [mlcic_pkg::CFG_W-1:0]      cfg_data
);
  import mlcic_pkg::*;

  localparam int AW  = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
  localparam int CW  = $clog2(MAX_BLOCKS + 1);
  localparam int NW  = (CW > CFG_W) ? CW : CFG_W;
  localparam int LIW = (NUM_LEVELS > 1) ? $clog2(NUM_LEVELS) : 1;
  localparam int LW  = $clog2(NUM_LEVELS + 1);

  localparam logic [LW-1:0]  LVL_NONE = LW'(NUM_LEVELS);
  localparam logic [LIW-1:0] LVL_LAST = LIW'(NUM_LEVELS - 1);
  localparam logic [CW-1:0]  BLK_LAST = CW'(MAX_BLOCKS - 1);
  localparam logic [NW-1:0]  BLK_MAX  = NW'(MAX_BLOCKS);

  // config
  logic [CFG_W-1:0] blocks_in_use;
  logic             notify_enable;

  // sequencer
  state_t state, state_next;

  // item
  logic                  lookup_r;
  logic                  set_r;
  logic [AW-1:0]         blk_r;
  logic [ID_W-1:0]       id_r;
  logic [CW-1:0]         n_last;
  logic [LIW-1:0]        lvl;
  logic [NUM_LEVELS-1:0] eq_mask;
  logic [LW-1:0]         found;
  logic [ID_W-1:0]       min_id;
  logic [LIW-1:0]        old;
  logic [CW-1:0]         cnt;
  logic                  chk_v;
  logic                  full_r;
  logic                  hit_r;
  logic [ID_W-1:0]       id_out_r;
  logic                  wb_r;
  logic                  comp_r;
  logic                  bad_r;

  // levels
  logic [ID_W-1:0] lid [NUM_LEVELS];
  logic [ID_W-1:0] latest;
  logic [ID_W-1:0] lid_rd;

  // memory port
  logic                  mem_we;
  logic [AW-1:0]         mem_waddr;
  logic [NUM_LEVELS-1:0] mem_wmask;
  logic [NUM_LEVELS-1:0] mem_wdata;
  logic [AW-1:0]         mem_raddr;
  logic [NUM_LEVELS-1:0] mem_rdata;

  // comparator
  logic [ID_W-1:0] cmp_a;
  logic [ID_W-1:0] cmp_b;
  cmp_res_t        cmp_res;

  logic [NW-1:0]  n_eff;
  logic [NW-1:0]  blk_ext;
  logic           blk_bad;
  logic           first_any;
  logic [LIW-1:0] first_idx;
  logic [LIW-1:0] fidx;

  mlcic_cmp u_cmp (
    .a   (cmp_a),
    .b   (cmp_b),
    .res (cmp_res)
  );

  mlcic_bitmem #(
    .DEPTH (MAX_BLOCKS),
    .WIDTH (NUM_LEVELS),
    .AW    (AW)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wmask (mem_wmask),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // config registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      blocks_in_use <= BLOCKS_IN_USE_RST;
      notify_enable <= 1'b1;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_BLOCKS_IN_USE: blocks_in_use <= cfg_data;
        REG_NOTIFY_ENABLE: notify_enable <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // block range
  always_comb begin
    n_eff   = (NW'(blocks_in_use) > BLK_MAX) ? BLK_MAX : NW'(blocks_in_use);
    blk_ext = NW'(block_index);
    blk_bad = (blk_ext >= n_eff);
  end

  // lowest level holding the block
  always_comb begin
    first_any = 1'b0;
    first_idx = '0;
    for (int i = NUM_LEVELS - 1; i >= 0; i--) begin
      if (mem_rdata[i]) begin
        first_any = 1'b1;
        first_idx = LIW'(i);
      end
    end
  end

  assign lid_rd = lid[lvl];
  assign fidx   = found[LIW-1:0];

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_CLEAR:    if (cnt == BLK_LAST) state_next = ST_IDLE;
      ST_IDLE:     if (start) state_next = blk_bad ? ST_DONE : ST_READ;
      ST_READ: begin
        if (lookup_r) state_next = first_any ? ST_LOOK : ST_DONE;
        else          state_next = ST_MATCH;
      end
      ST_LOOK:     state_next = ST_DONE;
      ST_MATCH: begin
        if (lvl == LVL_LAST) begin
          state_next = ((|eq_mask) || cmp_res.eq) ? ST_WRITE : ST_OLDEST;
        end
      end
      ST_OLDEST:   if (lvl == LVL_LAST) state_next = ST_DECIDE;
      ST_DECIDE:   state_next = cmp_res.lt ? ST_SWEEP : ST_WRITE;
      ST_SWEEP:    if (cnt == BLK_LAST) state_next = ST_NEWEST;
      ST_NEWEST:   state_next = ST_WRITE;
      ST_WRITE: begin
        state_next = ((found != LVL_NONE) && notify_enable) ? ST_SCAN : ST_DONE;
      end
      ST_SCAN:     if (cnt == n_last) state_next = ST_SCAN_END;
      ST_SCAN_END: state_next = ST_DONE;
      ST_DONE:     state_next = ST_IDLE;
      default:     state_next = ST_IDLE;
    endcase
  end

  // memory and comparator control
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = blk_r;
    mem_wmask = '1;
    mem_wdata = '0;
    mem_raddr = AW'(block_index);
    cmp_a     = lid_rd;
    cmp_b     = id_r;
    case (state)
      ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = cnt[AW-1:0];
      end
      ST_OLDEST: cmp_b = min_id;
      ST_DECIDE: begin
        cmp_a = min_id;
        cmp_b = id_r;
      end
      ST_SWEEP: begin
        mem_we    = 1'b1;
        mem_waddr = cnt[AW-1:0];
        mem_wmask = NUM_LEVELS'(1) << old;
      end
      ST_NEWEST: begin
        cmp_a = latest;
        cmp_b = id_r;
      end
      ST_WRITE: begin
        mem_we    = 1'b1;
        mem_wdata = eq_mask;
      end
      ST_SCAN: mem_raddr = cnt[AW-1:0];
      default: ;
    endcase
  end

  // sequencer and datapath registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= ST_CLEAR;
      cnt    <= '0;
      chk_v  <= 1'b0;
      latest <= '0;
      for (int i = 0; i < NUM_LEVELS; i++) begin
        lid[i] <= '0;
      end
    end else begin
      state <= state_next;
      case (state)
        ST_CLEAR: cnt <= cnt + 1'b1;
        ST_IDLE: begin
          if (start) begin
            lookup_r <= (cmd != CMD_SET) && (cmd != CMD_FILL);
            set_r    <= (cmd == CMD_SET);
            blk_r    <= AW'(block_index);
            id_r     <= change_id;
            n_last   <= CW'(n_eff - 1'b1);
            bad_r    <= blk_bad;
            hit_r    <= 1'b0;
            id_out_r <= change_id;
            found    <= LVL_NONE;
            wb_r     <= 1'b0;
            comp_r   <= 1'b0;
            eq_mask  <= '0;
            lvl      <= '0;
            cnt      <= '0;
            full_r   <= 1'b1;
            chk_v    <= 1'b0;
          end
        end
        ST_READ: begin
          if (lookup_r && first_any) begin
            found <= LW'(first_idx);
            lvl   <= first_idx;
          end
        end
        ST_LOOK: begin
          hit_r    <= 1'b1;
          id_out_r <= lid_rd;
        end
        ST_MATCH: begin
          eq_mask[lvl] <= cmp_res.eq;
          if (cmp_res.eq) found <= LW'(lvl);
          lvl <= (lvl == LVL_LAST) ? '0 : lvl + 1'b1;
        end
        ST_OLDEST: begin
          if ((lvl == '0) || cmp_res.lt) begin
            min_id <= lid_rd;
            old    <= lvl;
          end
          lvl <= lvl + 1'b1;
        end
        ST_DECIDE: begin
          if (cmp_res.lt) begin
            lid[old]     <= id_r;
            found        <= LW'(old);
            eq_mask[old] <= 1'b1;
            cnt          <= '0;
          end
        end
        ST_SWEEP: cnt <= cnt + 1'b1;
        ST_NEWEST: if (cmp_res.lt) latest <= id_r;
        ST_WRITE: begin
          wb_r  <= set_r && (found == LVL_NONE);
          cnt   <= '0;
          chk_v <= 1'b0;
        end
        ST_SCAN: begin
          cnt   <= cnt + 1'b1;
          chk_v <= 1'b1;
          if (chk_v && !mem_rdata[fidx]) full_r <= 1'b0;
        end
        ST_SCAN_END: begin
          comp_r <= full_r && mem_rdata[fidx];
          chk_v  <= 1'b0;
        end
        default: ;
      endcase
    end
  end

  assign busy           = (state != ST_IDLE);
  assign done           = (state == ST_DONE);
  assign hit            = hit_r;
  assign id_out         = id_out_r;
  assign level_used     = LVL_OUT_W'(found);
  assign writeback_req  = wb_r;
  assign level_complete = comp_r;
  assign latest_id      = latest;
  assign bad_block      = bad_r;

endmodule

// ----- rtl/core/mlcic_cmp.sv -----
// ----------------------------------------------------------------------------
// mlcic_cmp
// Shared 32-bit unsigned comparator: equal and less-than.
// ----------------------------------------------------------------------------
module mlcic_cmp (
  input  logic [mlcic_pkg::ID_W-1:0] a,
  input  logic [mlcic_pkg::ID_W-1:0] b,
  output mlcic_pkg::cmp_res_t        res
);
  import mlcic_pkg::*;

  always_comb begin
    res.eq = (a == b);
    res.lt = (a < b);
  end

endmodule

// ----- rtl/core/mlcic_bitmem.sv -----
// ----------------------------------------------------------------------------
// mlcic_bitmem
// Level membership memory: one row per block, per-bit write mask,
// registered read.
// ----------------------------------------------------------------------------
module mlcic_bitmem #(
  parameter int DEPTH = 256,
  parameter int WIDTH = 5,
  parameter int AW    = 8
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wmask,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      for (int i = 0; i < WIDTH; i++) begin
        if (wmask[i]) begin
          mem[waddr][i] <= wdata[i];
        end
      end
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- rtl/core/mlcic_checker.sv -----
// ----------------------------------------------------------------------------
// mlcic_checker
// Port-level checks of the change-id cache, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module mlcic_checker (
  input logic clk,
  input logic rst,
  input logic start,
  input logic busy,
  input logic done,
  input logic hit,
  input logic writeback_req,
  input logic level_complete,
  input logic bad_block
);

  `ASSERT_NEXT(a_accept_busy, clk, rst, start && !busy, busy, "accepted item did not raise busy")

  `ASSERT_IMPL(a_done_busy, clk, rst, done, busy, "result shown while idle")

  `ASSERT_NEXT(a_done_release, clk, rst, done, !busy && !done, "block not ready after result")

  `ASSERT_IMPL(a_bad_quiet, clk, rst, done && bad_block, !hit && !writeback_req && !level_complete, "bad block result carries side bits")

  `ASSERT_IMPL(a_hit_side, clk, rst, done && hit, !writeback_req && !level_complete && !bad_block, "lookup hit with set side bits")

endmodule

bind multilevel_change_id_cache_top mlcic_checker u_mlcic_checker (.*);

// ----- tb/sv/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the multilevel change-id cache. A cycle-free
// model of the levels, ids and membership bitmaps predicts every result.
// Each strobed result is compared field by field with the oldest
// prediction. Directed tests cover the reset state, oldest-level takeover,
// writeback, block bounds and completion. Random phases then run under
// several register settings with bursty command traffic.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import mlcic_pkg::*;

  localparam int NLVL = DEF_NUM_LEVELS;
  localparam int NBLK = DEF_MAX_BLOCKS;
  localparam logic [CMD_W-1:0] CMD_LOOKUP = 2'd2;
  localparam logic [CMD_W-1:0] CMD_RSVD   = 2'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_2 = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_3 = 2'd3;
  localparam logic [LVL_OUT_W-1:0] NO_LEVEL = LVL_OUT_W'(NLVL);
  localparam int SETTLE_CYCLES = 8;

  typedef struct packed {
    logic                 hit;
    logic [ID_W-1:0]      id_out;
    logic [LVL_OUT_W-1:0] level_used;
    logic                 writeback_req;
    logic                 level_complete;
    logic [ID_W-1:0]      latest_id;
    logic                 bad_block;
  } cache_result_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 start = 1'b0;
  logic                 busy;
  logic [CMD_W-1:0]     cmd = '0;
  logic [BLK_W-1:0]     block_index = '0;
  logic [ID_W-1:0]      change_id = '0;
  logic                 done;
  logic                 hit;
  logic [ID_W-1:0]      id_out;
  logic [LVL_OUT_W-1:0] level_used;
  logic                 writeback_req;
  logic                 level_complete;
  logic [ID_W-1:0]      latest_id;
  logic                 bad_block;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0]     cfg_data = '0;

  multilevel_change_id_cache_top u_top (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .cmd(cmd), .block_index(block_index), .change_id(change_id),
    .done(done), .hit(hit), .id_out(id_out), .level_used(level_used),
    .writeback_req(writeback_req), .level_complete(level_complete),
    .latest_id(latest_id), .bad_block(bad_block),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // model state
  logic [NLVL-1:0]  lvl_member [NBLK];
  logic [ID_W-1:0]  lvl_id [NLVL];
  logic [CFG_W-1:0] blocks_cfg;
  logic             notify_cfg;

  cache_result_t expected_results [$];
  int errors = 0;
  int items_sent = 0;
  int results_seen = 0;
  int cfg_writes = 0;
  int completions = 0;
  int writebacks = 0;
  int burst_left = 0;

  function automatic int eff_blocks();
    return (blocks_cfg > NBLK) ? NBLK : int'(blocks_cfg);
  endfunction

  function automatic cache_result_t cache_predict(input logic [CMD_W-1:0] c,
                                                  input logic [BLK_W-1:0] b,
                                                  input logic [ID_W-1:0] id);
    cache_result_t r;
    int n;
    int found;
    int old;
    logic full;
    n = eff_blocks();
    r = '0;
    r.id_out = id;
    r.level_used = NO_LEVEL;
    if (b >= n) begin
      r.bad_block = 1'b1;
    end else if (c == CMD_LOOKUP || c == CMD_RSVD) begin
      for (int i = 0; i < NLVL; i++) begin
        if (!r.hit && lvl_member[b][i]) begin
          r.hit = 1'b1;
          r.id_out = lvl_id[i];
          r.level_used = LVL_OUT_W'(i);
        end
      end
    end else begin
      found = -1;
      for (int i = 0; i < NLVL; i++) begin
        lvl_member[b][i] = (lvl_id[i] == id);
        if (lvl_id[i] == id) found = i;
      end
      if (found < 0) begin
        old = 0;
        for (int j = 1; j < NLVL; j++)
          if (lvl_id[j] < lvl_id[old]) old = j;
        if (lvl_id[old] < id) begin
          lvl_id[old] = id;
          for (int k = 0; k < NBLK; k++) lvl_member[k][old] = 1'b0;
          lvl_member[b][old] = 1'b1;
          found = old;
        end
      end
      if (found < 0) begin
        r.writeback_req = (c == CMD_SET);
      end else begin
        r.level_used = LVL_OUT_W'(found);
        if (notify_cfg) begin
          full = 1'b1;
          for (int k = 0; k < n; k++)
            if (!lvl_member[k][found]) full = 1'b0;
          r.level_complete = full;
        end
      end
    end
    r.latest_id = '0;
    for (int i = 0; i < NLVL; i++)
      if (lvl_id[i] > r.latest_id) r.latest_id = lvl_id[i];
    return r;
  endfunction

  task automatic check_field(input string name, input logic [ID_W-1:0] want,
                             input logic [ID_W-1:0] got);
    if (want !== got) begin
      errors++;
      $display("%0t ns: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, want, got);
    end
  endtask

  always @(posedge clk) begin : result_checker
    cache_result_t want;
    if (!rst && done) begin
      results_seen++;
      if (expected_results.size() == 0) begin
        errors++;
        $display("%0t ns: result with no item outstanding, expected none, actual hit=%0b id=0x%0h",
                 $time, hit, id_out);
      end else begin
        want = expected_results.pop_front();
        check_field("hit", ID_W'(want.hit), ID_W'(hit));
        check_field("id_out", want.id_out, id_out);
        check_field("level_used", ID_W'(want.level_used), ID_W'(level_used));
        check_field("writeback_req", ID_W'(want.writeback_req), ID_W'(writeback_req));
        check_field("level_complete", ID_W'(want.level_complete), ID_W'(level_complete));
        check_field("latest_id", want.latest_id, latest_id);
        check_field("bad_block", ID_W'(want.bad_block), ID_W'(bad_block));
        if (want.level_complete) completions++;
        if (want.writeback_req) writebacks++;
      end
    end
  end

  task automatic send_item(input logic [CMD_W-1:0] c, input logic [BLK_W-1:0] b,
                           input logic [ID_W-1:0] id);
    start <= 1'b1;
    cmd <= c;
    block_index <= b;
    change_id <= id;
    do @(posedge clk); while (busy);
    expected_results.push_back(cache_predict(c, b, id));
    items_sent++;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      start <= 1'b0;
      repeat ($urandom_range(1, ($urandom_range(0, 4) == 0) ? 40 : 6)) @(posedge clk);
      burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(30, 80) : $urandom_range(0, 8);
    end
  endtask

  task automatic wait_drained();
    start <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == REG_BLOCKS_IN_USE) blocks_cfg = data;
    else if (idx == REG_NOTIFY_ENABLE) notify_cfg = data[0];
    cfg_writes++;
    @(posedge clk);
  endtask

  task automatic set_config(input logic [CFG_W-1:0] blocks, input logic notify);
    wait_drained();
    cfg_write(REG_BLOCKS_IN_USE, blocks);
    cfg_write(REG_NOTIFY_ENABLE, {(CFG_W-1)'($urandom_range(0, 255)), notify});
    // unmapped indexes must be ignored
    cfg_write(REG_SPARE_2, CFG_W'($urandom()));
    cfg_write(REG_SPARE_3, CFG_W'($urandom()));
  endtask

  task automatic test_reset_state();
    send_item(CMD_LOOKUP, 8'd0, 32'h1234_5678);
    send_item(CMD_SET, 8'd0, 32'h0);
    send_item(CMD_LOOKUP, 8'd0, 32'hFFFF_FFFF);
    send_item(CMD_RSVD, 8'd0, 32'h0);
    send_item(CMD_FILL, 8'd255, 32'hFFFF_FFFF);
    send_item(CMD_LOOKUP, 8'd255, 32'h0);
    send_item(CMD_LOOKUP, 8'd0, 32'h0);
  endtask

  task automatic test_takeover_writeback();
    send_item(CMD_FILL, 8'd2, 32'd5);
    send_item(CMD_FILL, 8'd2, 32'd6);
    send_item(CMD_FILL, 8'd2, 32'd7);
    send_item(CMD_FILL, 8'd2, 32'd8);
    send_item(CMD_SET, 8'd3, 32'd3);
    send_item(CMD_FILL, 8'd3, 32'd3);
    send_item(CMD_LOOKUP, 8'd3, 32'd9);
    send_item(CMD_SET, 8'd3, 32'd6);
  endtask

  task automatic test_block_bounds();
    set_config(9'd16, 1'b1);
    send_item(CMD_SET, 8'd16, 32'd6);
    send_item(CMD_LOOKUP, 8'd255, 32'd1);
    send_item(CMD_SET, 8'd15, 32'd6);
    set_config(9'd0, 1'b1);
    send_item(CMD_LOOKUP, 8'd0, 32'd2);
    set_config(9'd300, 1'b1);
    send_item(CMD_LOOKUP, 8'd255, 32'd3);
  endtask

  task automatic test_completion();
    set_config(9'd1, 1'b1);
    send_item(CMD_SET, 8'd0, 32'd7);
    set_config(9'd1, 1'b0);
    send_item(CMD_FILL, 8'd0, 32'd7);
  endtask

  task automatic test_random(input logic [CFG_W-1:0] blocks, input logic notify,
                             input int n_items);
    int cnt;
    int eff;
    int r;
    logic [ID_W-1:0] cur;
    logic [ID_W-1:0] id;
    logic [BLK_W-1:0] b;
    logic [CMD_W-1:0] c;
    set_config(blocks, notify);
    eff = eff_blocks();
    cur = $urandom();
    cnt = 0;
    while (cnt < n_items) begin
      if (eff > 0 && eff <= 40 && $urandom_range(0, 99) < 2) begin
        // fill every block with one id so a level can complete
        c = ($urandom_range(0, 1) == 0) ? CMD_SET : CMD_FILL;
        for (int k = 0; k < eff && cnt < n_items; k++) begin
          send_item(c, BLK_W'(k), cur);
          cnt++;
        end
      end else begin
        r = $urandom_range(0, 99);
        if (r < 40) c = CMD_SET;
        else if (r < 65) c = CMD_FILL;
        else if (r < 95) c = CMD_LOOKUP;
        else c = CMD_RSVD;
        if (eff == 0 || $urandom_range(0, 9) == 0) b = BLK_W'($urandom_range(0, 255));
        else b = BLK_W'($urandom_range(0, eff - 1));
        r = $urandom_range(0, 99);
        if (r < 65) begin
          id = cur - ID_W'($urandom_range(0, 7));
        end else if (r < 80) begin
          cur = cur + ID_W'($urandom_range(1, 3));
          id = cur;
        end else if (r < 95) begin
          id = $urandom();
        end else begin
          id = (r[0]) ? '0 : '1;
        end
        send_item(c, b, id);
        cnt++;
      end
    end
  endtask

  initial begin : limit
    #40_000_000;
    $display("Verification failed");
    $finish;
  end

  initial begin : main
    for (int k = 0; k < NBLK; k++) lvl_member[k] = '0;
    for (int i = 0; i < NLVL; i++) lvl_id[i] = '0;
    blocks_cfg = BLOCKS_IN_USE_RST;
    notify_cfg = 1'b1;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_reset_state();
    test_takeover_writeback();
    test_block_bounds();
    test_completion();

    test_random(9'd256, 1'b1, 150);
    test_random(9'd16, 1'b1, 500);
    test_random(9'd479, 1'b1, 150);
    test_random(9'd1, 1'b1, 150);
    test_random(9'd0, 1'b1, 50);
    test_random(9'd40, 1'b0, 400);
    test_random(9'd8, 1'b1, 400);
    test_random(9'd256, 1'b0, 150);

    wait_drained();
    $display("Ran %0d items (%0d results, %0d completions, %0d writebacks) over %0d",
             items_sent, results_seen, completions, writebacks, cfg_writes);
    $display("register writes, block counts 0 to 479, notify on and off.");
    if (errors == 0 && expected_results.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
